// ===== hw/rtl/oth_pkg.sv =====
// Shared types and codes for the ordered table block.
package oth_pkg;

  localparam int DEPTH    = 64;

  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 7;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 8;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic put;
    logic finish;
  } oth_cmd_t;

  typedef struct packed {
    logic err;
    logic need_scan;
    logic is_add;
    logic last;
    logic hit;
    logic out_free;
  } oth_stat_t;

endpackage

// ===== hw/rtl/ordered_table_with_shift_top.sv =====
// Each word passes through load and check, then an optional walk through the entry RAM (insert,
// remove, pop, find, read), an optional put of the new item (append, insert) and a finish
// that registers the result once the output is free. Throughput: one word at a time; the
// walk reads one entry per cycle, and a find stops its walk at the first match.
// Reset (synchronous): count 0, capacity 1, no result pending; entry storage is not cleared.
module ordered_table_with_shift_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [oth_pkg::FUNC_W-1:0]          func,
  input  logic [oth_pkg::INDEX_W-1:0]         index,
  input  logic signed [oth_pkg::WORD_W-1:0]   item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [oth_pkg::STATUS_W-1:0]        status,
  output logic signed [oth_pkg::WORD_W-1:0]   value,
  output logic                                found,
  output logic signed [oth_pkg::POS_W-1:0]    position,
  output logic [oth_pkg::COUNT_W-1:0]         count,
  output logic [oth_pkg::CAP_W-1:0]           capacity,
  output logic                                empty_res
);
  import oth_pkg::*;

  oth_cmd_t  cmd;
  oth_stat_t st;

  oth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  oth_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .func       (func),
    .index      (index),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .value      (value),
    .found      (found),
    .position   (position),
    .count      (count),
    .capacity   (capacity),
    .empty_res  (empty_res)
  );

endmodule

// ===== hw/rtl/oth_ram.sv =====
// Generic simple dual-port RAM with registered read.
module oth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/oth_ctrl.sv =====
// Controller state machine for the ordered table block.
module oth_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  oth_pkg::oth_stat_t st,
  output oth_pkg::oth_cmd_t  cmd
);
  import oth_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_PUT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.err) begin
          state_next = S_FINISH;
        end else if (st.need_scan) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end else if (st.is_add) begin
          state_next = S_PUT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        // stop a search as soon as a match comes back
        if (st.hit) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
          if (st.last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_next = st.is_add ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== hw/rtl/oth_dp.sv =====
// Datapath: entry storage, walk pointer, count, capacity and result register.
module oth_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  oth_pkg::oth_cmd_t                   cmd,
  output oth_pkg::oth_stat_t                  st,
  input  logic [oth_pkg::FUNC_W-1:0]          func,
  input  logic [oth_pkg::INDEX_W-1:0]         index,
  input  logic signed [oth_pkg::WORD_W-1:0]   item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [oth_pkg::STATUS_W-1:0]        status,
  output logic signed [oth_pkg::WORD_W-1:0]   value,
  output logic                                found,
  output logic signed [oth_pkg::POS_W-1:0]    position,
  output logic [oth_pkg::COUNT_W-1:0]         count,
  output logic [oth_pkg::CAP_W-1:0]           capacity,
  output logic                                empty_res
);
  import oth_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int PW = CW + 1;
  localparam int KW = CW + 2;

  logic [CW-1:0]     cnt;
  logic [PW-1:0]     cap;
  logic [FUNC_W-1:0] fn_r;
  logic [IW-1:0]     idx_r;
  logic [WORD_W-1:0] item_r;
  logic [WORD_W-1:0] value_r;
  logic              found_r;
  logic [AW-1:0]     pos_r;
  logic [AW-1:0]     ptr;
  logic              pend;
  logic [AW-1:0]     pend_a;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;

  logic [IW-1:0]       cnt_w;
  logic                is_add;
  logic                is_del;
  logic                is_find;
  logic                is_read;
  logic                tbl_full;
  logic                tbl_empty;
  logic [STATUS_W-1:0] code;
  logic                ok;
  logic [AW-1:0]       idx_a;
  logic [AW-1:0]       last_a;
  logic [AW-1:0]       start_a;
  logic [AW-1:0]       end_a;
  logic                hit;
  logic                out_free;
  logic [CW-1:0]       cnt_next;
  logic [PW-1:0]       cap_grow;
  logic [PW-1:0]       cap_next;

  oth_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.step),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  assign cnt_w     = IW'(cnt);
  assign is_add    = (fn_r == FN_APPEND) || (fn_r == FN_INSERT);
  assign is_del    = (fn_r == FN_POP) || (fn_r == FN_REMOVE);
  assign is_find   = (fn_r == FN_FIND);
  assign is_read   = (fn_r == FN_READ);
  assign tbl_full  = (cnt == CW'(DEPTH));
  assign tbl_empty = (cnt == '0);
  assign idx_a     = idx_r[AW-1:0];
  assign last_a    = AW'(cnt - 1'b1);

  always_comb begin
    code = ST_OK;
    if (is_add) begin
      if (tbl_full) begin
        code = ST_FULL;
      end else if (idx_r > cnt_w) begin
        code = ST_RANGE;
      end
    end else if (is_del) begin
      if (tbl_empty) begin
        code = ST_EMPTY;
      end else if (idx_r >= cnt_w) begin
        code = ST_RANGE;
      end
    end else if (is_read) begin
      if (idx_r >= cnt_w) begin
        code = ST_RANGE;
      end
    end
  end

  assign ok = (code == ST_OK);

  // insert walks down from the last entry, everything else walks up
  assign start_a = is_add ? last_a : (is_find ? '0 : idx_a);
  assign end_a   = is_add ? idx_a : ((is_find || is_del) ? last_a : idx_a);

  assign hit      = pend && is_find && (rd_data == item_r);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    st           = '0;
    st.err       = !ok;
    st.is_add    = is_add;
    st.last      = (ptr == end_a);
    st.hit       = hit;
    st.out_free  = out_free;
    st.need_scan = is_add ? (idx_r < cnt_w) :
                   (is_find ? !tbl_empty : (is_del || is_read));
  end

  // write back the word read in the previous cycle, shifted by one place, or the new item on a put
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_a;
    wr_data = rd_data;
    if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = idx_a;
      wr_data = item_r;
    end else if (pend) begin
      if (is_add) begin
        wr_en   = 1'b1;
        wr_addr = AW'(pend_a + 1'b1);
      end else if (is_del && (pend_a != idx_a)) begin
        wr_en   = 1'b1;
        wr_addr = AW'(pend_a - 1'b1);
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ok && is_add) begin
      cnt_next = CW'(cnt + 1'b1);
    end else if (ok && is_del) begin
      cnt_next = CW'(cnt - 1'b1);
    end
    cap_grow = (PW'(cnt_next) == cap) ? PW'({cap, 1'b0}) : cap;
    cap_next = cap;
    if (ok && (is_add || is_del)) begin
      if ((cap_grow > PW'(4)) && ((KW'(cnt_next) << 2) <= KW'(cap_grow))) begin
        cap_next = cap_grow >> 1;
      end else begin
        cap_next = cap_grow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cap       <= PW'(1);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.step;
      if (cmd.finish) begin
        cnt       <= cnt_next;
        cap       <= cap_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r    <= func;
      item_r  <= item_value;
      found_r <= 1'b0;
      case (func)
        FN_APPEND: idx_r <= IW'(cnt);
        FN_POP:    idx_r <= IW'(CW'(cnt - 1'b1));
        default:   idx_r <= IW'(index);
      endcase
    end
    if (cmd.start) begin
      ptr <= start_a;
    end else if (cmd.step) begin
      ptr <= is_add ? AW'(ptr - 1'b1) : AW'(ptr + 1'b1);
    end
    if (cmd.step) begin
      pend_a <= ptr;
    end
    if (pend && ((is_del && (pend_a == idx_a)) || is_read)) begin
      value_r <= rd_data;
    end
    if (hit && !found_r) begin
      found_r <= 1'b1;
      pos_r   <= pend_a;
    end
    if (cmd.finish) begin
      status    <= code;
      value     <= !ok ? '1 : ((is_del || is_read) ? value_r : '0);
      found     <= found_r;
      position  <= found_r ? POS_W'(pos_r) : '1;
      count     <= COUNT_W'(cnt_next);
      capacity  <= CAP_W'(cap_next);
      empty_res <= (cnt_next == '0);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cap_pow2: assert property (@(posedge clk) disable iff (rst)
    $onehot(cap))
    else $error("capacity not a power of two");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.finish) |-> $stable(cnt))
    else $error("entry count changed outside commit");

endmodule
